// ===== design/nlic_pkg.sv =====
// Package for the nested loop index counter.
// Holds the request and response types, command and status codes, and the
// control struct that drives one loop cell. No dependencies.
package nlic_pkg;

   localparam int DATA_W  = 32;
   localparam int LEVEL_W = 4;

   localparam logic [1:0] CMD_APPEND   = 2'd0;
   localparam logic [1:0] CMD_END_BODY = 2'd1;
   localparam logic [1:0] CMD_CONTINUE = 2'd2;
   localparam logic [1:0] CMD_READ     = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_HALT  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;
   localparam logic [1:0] STATUS_FULL  = 2'd3;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [LEVEL_W-1:0]       level;
      logic signed [DATA_W-1:0] start_value;
      logic signed [DATA_W-1:0] end_value;
      logic signed [DATA_W-1:0] step_value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] value;
      logic                     done_res;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic reload;
      logic adv;
      logic outermost;
   } cell_ctrl_type;

endpackage

// ===== design/nlic_cell.sv =====
// One loop level of the nested loop index counter.
// Stores start, end, step and value, precomputes the next value and its
// carry, and passes carries outward. Depends on nlic_pkg.
module nlic_cell
   import nlic_pkg::*;
(
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic signed [DATA_W-1:0] start_in,
   input  logic signed [DATA_W-1:0] end_in,
   input  logic signed [DATA_W-1:0] step_in,
   input  logic                     carry_in,
   output logic                     carry_out,
   output logic signed [DATA_W-1:0] value_out,
   output logic                     past_end
);

   logic signed [DATA_W-1:0] start_ff, start_in_w;
   logic signed [DATA_W-1:0] end_ff, end_in_w;
   logic signed [DATA_W-1:0] step_ff, step_in_w;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic signed [DATA_W-1:0] sum_ff, sum_in;
   logic                     wrap_ff, wrap_in;
   logic                     eq_ff, eq_in;
   logic signed [DATA_W:0]   sum_wide;
   logic signed [DATA_W:0]   end_wide;
   logic                     count_up;
   logic                     count_down;
   logic                     adv;

   assign count_up   = start_ff < end_ff;
   assign count_down = start_ff > end_ff;
   assign sum_wide   = {value_ff[DATA_W-1], value_ff} + {step_ff[DATA_W-1], step_ff};
   assign end_wide   = {end_ff[DATA_W-1], end_ff};
   assign adv        = ctrl.adv | carry_in;
   assign carry_out  = adv & wrap_ff & ~ctrl.outermost;
   assign value_out  = value_ff;

   always_comb begin
      if (count_up) begin
         past_end = value_ff > end_ff;
      end else if (count_down) begin
         past_end = value_ff < end_ff;
      end else begin
         past_end = value_ff != end_ff;
      end
   end

   always_comb begin
      sum_in = sum_wide[DATA_W-1:0];
      eq_in  = start_ff == end_ff;
      if (count_up) begin
         wrap_in = sum_wide > end_wide;
      end else if (count_down) begin
         wrap_in = sum_wide < end_wide;
      end else begin
         wrap_in = 1'b1;
      end
   end

   always_comb begin
      start_in_w = start_ff;
      end_in_w   = end_ff;
      step_in_w  = step_ff;
      value_in   = value_ff;
      if (ctrl.load) begin
         start_in_w = start_in;
         end_in_w   = end_in;
         step_in_w  = step_in;
         value_in   = start_in;
      end else if (adv) begin
         if (ctrl.outermost || !wrap_ff) begin
            value_in = sum_ff;
         end else if (!eq_ff) begin
            value_in = start_ff;
         end
      end else if (ctrl.reload) begin
         value_in = start_ff;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in_w;
      end_ff   <= end_in_w;
      step_ff  <= step_in_w;
      value_ff <= value_in;
      sum_ff   <= sum_in;
      wrap_ff  <= wrap_in;
      eq_ff    <= eq_in;
   end

endmodule

// ===== design/nested_loop_index_counter.sv =====
// Top level of the nested loop index counter.
// Holds the command sequencer and a chain of nlic_cell loop levels.
// Depends on nlic_pkg and nlic_cell.
//
// Usage: the host sends requests on req_valid/req_stall/req_data: append a
// level (outermost first), end of body, continue at a level, or read a
// level value. Each request yields exactly one response on
// rsp_valid/rsp_stall/rsp_data with a status, the read value and the done
// flag of the outermost level.
// Timing: a request is taken, executed in the next cycle, and its result
// then waits in the settle stage until the response register is free and
// is registered as the response. A new request is taken in the same cycle
// as the previous response is loaded, but never while one is executing.
// The pace is set by the cells, which register their next value and carry
// in the cycle after any change. Carries ripple from the innermost advancing
// level outward through the cell chain within the execute cycle.
// Reset clears the level count, the halt and continue flags and the
// sequencer; the level storage keeps its contents and is not read until
// written. While rsp_stall holds a response, the result of the next request
// waits in the settle stage and req_stall stays high.
module nested_loop_index_counter
   import nlic_pkg::*;
#(
   parameter int MAX_LEVELS = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(MAX_LEVELS + 1);
   localparam int LW = (CW > LEVEL_W) ? CW : LEVEL_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_SETTLE = 2'd2;

   logic [1:0]               state_ff, state_in;
   req_type                  req_ff, req_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     cont_ff, cont_in;
   logic                     halted_ff, halted_in;
   logic [1:0]               status_ff, status_in;
   logic signed [DATA_W-1:0] rdval_ff, rdval_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     accept;
   logic                     rsp_free;
   logic                     done_now;
   logic                     do_load;
   logic                     do_reload;
   logic                     do_adv;
   logic [LW-1:0]            lvl_x;
   logic [LW-1:0]            count_x;
   logic [LW-1:0]            target_x;
   logic                     lvl_ok;
   logic                     reject;
   logic signed [DATA_W-1:0] rd_value;

   logic                     carry_link [0:MAX_LEVELS];
   logic signed [DATA_W-1:0] cell_value [0:MAX_LEVELS-1];
   logic                     cell_past  [0:MAX_LEVELS-1];

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_SETTLE) && rsp_free));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign lvl_x    = LW'(req_ff.level);
   assign count_x  = LW'(count_ff);
   assign target_x = count_x - LW'(1);
   assign lvl_ok   = lvl_x < count_x;
   assign done_now = (count_ff != '0) && cell_past[0];
   assign reject   = ((req_ff.start_value > req_ff.end_value) && (req_ff.step_value > 0)) ||
                     ((req_ff.start_value < req_ff.end_value) && (req_ff.step_value < 0));

   assign carry_link[MAX_LEVELS] = 1'b0;

   for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
      cell_ctrl_type ctrl;

      always_comb begin
         ctrl.load      = do_load && (count_x == LW'(i));
         ctrl.reload    = do_reload && (LW'(i) > lvl_x);
         ctrl.adv       = do_adv && (((req_ff.cmd == CMD_CONTINUE) ? lvl_x : target_x) == LW'(i));
         ctrl.outermost = (i == 0);
      end

      nlic_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .start_in  (req_ff.start_value),
         .end_in    (req_ff.end_value),
         .step_in   (req_ff.step_value),
         .carry_in  (carry_link[i+1]),
         .carry_out (carry_link[i]),
         .value_out (cell_value[i]),
         .past_end  (cell_past[i])
      );
   end

   always_comb begin
      rd_value = '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
         if (lvl_x == LW'(i)) begin
            rd_value = cell_value[i];
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      cont_in   = cont_ff;
      halted_in = halted_ff;
      status_in = status_ff;
      rdval_in  = rdval_ff;
      do_load   = 1'b0;
      do_reload = 1'b0;
      do_adv    = 1'b0;
      if (state_ff == ST_EXEC) begin
         status_in = STATUS_OK;
         rdval_in  = '0;
         if (halted_ff) begin
            status_in = STATUS_HALT;
         end else begin
            unique case (req_ff.cmd)
               CMD_APPEND: begin
                  if (count_x >= LW'(MAX_LEVELS)) begin
                     status_in = STATUS_FULL;
                  end else if (reject) begin
                     halted_in = 1'b1;
                     status_in = STATUS_HALT;
                  end else begin
                     do_load  = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end
               CMD_END_BODY: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_RANGE;
                  end else if (!done_now) begin
                     do_adv  = !cont_ff;
                     cont_in = 1'b0;
                  end
               end
               CMD_CONTINUE: begin
                  if (!lvl_ok) begin
                     status_in = STATUS_RANGE;
                  end else if (!done_now) begin
                     do_reload = 1'b1;
                     do_adv    = 1'b1;
                     cont_in   = 1'b1;
                  end
               end
               CMD_READ: begin
                  if (!lvl_ok) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     rdval_in = rd_value;
                  end
               end
               default: begin
                  status_in = STATUS_OK;
               end
            endcase
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_SETTLE;
         end
         ST_SETTLE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.status   = status_ff;
               rsp_in.value    = rdval_ff;
               rsp_in.done_res = done_now;
               state_in        = accept ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (accept) begin
         req_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cont_ff      <= 1'b0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cont_ff      <= cont_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
      rsp_ff    <= rsp_in;
   end

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      LW'(count_ff) <= LW'(MAX_LEVELS))
      else $error("Level count exceeds the table size.");

   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("Halt flag cleared without reset.");

   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("Accepted request did not enter execution.");

   a_rsp_from_settle : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |-> $past(state_ff == ST_SETTLE))
      else $error("Response loaded outside the settle cycle.");

   a_no_outer_carry : assert property (@(posedge clock) disable iff (reset)
      !carry_link[0])
      else $error("Carry left the outermost level.");
`endif

endmodule
